/* sv/svpwm_pkg.sv */
// Shared constants and types for the space vector PWM timing unit.
package svpwm_pkg;

  // Output duty field width (signed, fixed by the result format)
  localparam int OutWidth = 19;

  // 1/sqrt(3) in Q0.28
  localparam int KShift = 28;
  localparam logic [KShift-1:0] InvSqrt3Q28 = 28'd154981283;

  // Defaults for the top-level parameters
  localparam int FracBitsDefault = 14;
  localparam int InWidthDefault  = 16;

  // Sextant of the voltage vector
  typedef enum logic [2:0] {
    Sext1 = 3'd1,
    Sext2 = 3'd2,
    Sext3 = 3'd3,
    Sext4 = 3'd4,
    Sext5 = 3'd5,
    Sext6 = 3'd6
  } sextant_e;

endpackage

/* sv/svpwm_proj.sv */
// Scaled alpha and beta/sqrt(3) projection at the common product scale.
module svpwm_proj #(
  parameter int IN_WIDTH = svpwm_pkg::InWidthDefault,
  parameter int SUM_W    = 52
) (
  input  logic signed [IN_WIDTH-1:0] alpha_i,
  input  logic signed [IN_WIDTH-1:0] beta_i,
  output logic signed [SUM_W-1:0]    a_o,
  output logic signed [SUM_W-1:0]    p_o
);

  localparam int KS = svpwm_pkg::KShift;
  localparam int PW = IN_WIDTH + KS + 1;

  localparam logic signed [KS:0] KSigned = {1'b0, svpwm_pkg::InvSqrt3Q28};

  logic signed [PW-1:0] prod;

  assign prod = beta_i * KSigned;

  // Sign-extend both terms to the shared sum width
  assign a_o = {{(SUM_W-IN_WIDTH-KS){alpha_i[IN_WIDTH-1]}}, alpha_i, {KS{1'b0}}};
  assign p_o = {{(SUM_W-PW){prod[PW-1]}}, prod};

endmodule

/* sv/svpwm_sector.sv */
// Sextant selection and the two active vector on-times.
module svpwm_sector #(
  parameter int SUM_W = 52
) (
  input  logic signed [SUM_W-1:0] a_i,
  input  logic signed [SUM_W-1:0] p_i,
  output svpwm_pkg::sextant_e     sextant_o,
  output logic signed [SUM_W-1:0] x_o,
  output logic signed [SUM_W-1:0] y_o
);

  logic                    a_neg;
  logic                    b_neg;
  logic                    p_gt_a;
  logic                    np_gt_a;
  logic signed [SUM_W-1:0] neg_p;
  logic signed [SUM_W-1:0] a_minus_p;
  logic signed [SUM_W-1:0] a_plus_p;
  logic signed [SUM_W-1:0] two_p;
  logic signed [SUM_W-1:0] ta;
  logic signed [SUM_W-1:0] tb;

  assign a_neg     = a_i[SUM_W-1];
  assign b_neg     = p_i[SUM_W-1];
  assign neg_p     = -p_i;
  assign p_gt_a    = p_i > a_i;
  assign np_gt_a   = neg_p > a_i;
  assign a_minus_p = a_i - p_i;
  assign a_plus_p  = a_i + p_i;
  assign two_p     = p_i <<< 1;

  always_comb begin
    if (!b_neg) begin
      if (!a_neg) begin
        sextant_o = p_gt_a ? svpwm_pkg::Sext2 : svpwm_pkg::Sext1;
      end else begin
        sextant_o = np_gt_a ? svpwm_pkg::Sext3 : svpwm_pkg::Sext2;
      end
    end else begin
      if (!a_neg) begin
        sextant_o = np_gt_a ? svpwm_pkg::Sext5 : svpwm_pkg::Sext6;
      end else begin
        sextant_o = p_gt_a ? svpwm_pkg::Sext4 : svpwm_pkg::Sext5;
      end
    end
  end

  always_comb begin
    unique case (sextant_o)
      svpwm_pkg::Sext1: begin ta = a_minus_p;  tb = two_p;      end
      svpwm_pkg::Sext2: begin ta = a_plus_p;   tb = -a_minus_p; end
      svpwm_pkg::Sext3: begin ta = two_p;      tb = -a_plus_p;  end
      svpwm_pkg::Sext4: begin ta = -a_minus_p; tb = -two_p;     end
      svpwm_pkg::Sext5: begin ta = -a_plus_p;  tb = a_minus_p;  end
      default:          begin ta = -two_p;     tb = a_plus_p;   end
    endcase
  end

  // Odd sextants add ta first, even sextants tb first
  always_comb begin
    case (sextant_o)
      svpwm_pkg::Sext1, svpwm_pkg::Sext3, svpwm_pkg::Sext5: begin
        x_o = ta;
        y_o = tb;
      end
      default: begin
        x_o = tb;
        y_o = ta;
      end
    endcase
  end

endmodule

/* sv/svpwm_duty.sv */
// Phase duties from on-times: center alignment, rounding, range flag, saturation.
module svpwm_duty #(
  parameter int FRAC_BITS = svpwm_pkg::FracBitsDefault,
  parameter int SUM_W     = 52
) (
  input  svpwm_pkg::sextant_e                      sextant_i,
  input  logic signed [SUM_W-1:0]                  x_i,
  input  logic signed [SUM_W-1:0]                  y_i,
  output logic signed [svpwm_pkg::OutWidth-1:0]    duty_a_o,
  output logic signed [svpwm_pkg::OutWidth-1:0]    duty_b_o,
  output logic signed [svpwm_pkg::OutWidth-1:0]    duty_c_o,
  output logic                                     range_status_o
);

  localparam int KS   = svpwm_pkg::KShift;
  localparam int OW   = svpwm_pkg::OutWidth;
  localparam int QW   = SUM_W - KS - 1;

  localparam logic signed [SUM_W-1:0] OneD     = {{(SUM_W-1){1'b0}}, 1'b1} << (FRAC_BITS + KS);
  localparam logic signed [SUM_W-1:0] RoundOff = {{(SUM_W-1){1'b0}}, 1'b1} << KS;
  localparam logic signed [QW-1:0]    OneQ     = {{(QW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [QW-1:0]    SatHi    = ({{(QW-1){1'b0}}, 1'b1} << (OW - 1)) - 1'b1;
  localparam logic signed [QW-1:0]    SatLo    = ~SatHi;

  logic signed [SUM_W-1:0] d_first;
  logic signed [SUM_W-1:0] d_mid;
  logic signed [SUM_W-1:0] d_last;
  logic signed [SUM_W-1:0] r_first;
  logic signed [SUM_W-1:0] r_mid;
  logic signed [SUM_W-1:0] r_last;
  logic signed [QW-1:0]    q_first;
  logic signed [QW-1:0]    q_mid;
  logic signed [QW-1:0]    q_last;
  logic signed [OW-1:0]    s_first;
  logic signed [OW-1:0]    s_mid;
  logic signed [OW-1:0]    s_last;

  function automatic logic signed [OW-1:0] sat(input logic signed [QW-1:0] q);
    logic signed [OW-1:0] r;
    if (q > SatHi) begin
      r = SatHi[OW-1:0];
    end else if (q < SatLo) begin
      r = SatLo[OW-1:0];
    end else begin
      r = q[OW-1:0];
    end
    return r;
  endfunction

  function automatic logic out_of_range(input logic signed [QW-1:0] q);
    return q[QW-1] || (q > OneQ);
  endfunction

  // Zero vector time split evenly; duties held at twice their value
  assign d_first = OneD - x_i - y_i;
  assign d_mid   = d_first + (x_i <<< 1);
  assign d_last  = d_mid + (y_i <<< 1);

  // Round half up: add half an LSB, then floor
  assign r_first = d_first + RoundOff;
  assign r_mid   = d_mid + RoundOff;
  assign r_last  = d_last + RoundOff;
  assign q_first = r_first[SUM_W-1:KS+1];
  assign q_mid   = r_mid[SUM_W-1:KS+1];
  assign q_last  = r_last[SUM_W-1:KS+1];

  assign s_first = sat(q_first);
  assign s_mid   = sat(q_mid);
  assign s_last  = sat(q_last);

  assign range_status_o = out_of_range(q_first) || out_of_range(q_mid)
                          || out_of_range(q_last);

  // Route to phases by switching order of the sextant
  always_comb begin
    unique case (sextant_i)
      svpwm_pkg::Sext1: begin duty_a_o = s_first; duty_b_o = s_mid;   duty_c_o = s_last;  end
      svpwm_pkg::Sext2: begin duty_b_o = s_first; duty_a_o = s_mid;   duty_c_o = s_last;  end
      svpwm_pkg::Sext3: begin duty_b_o = s_first; duty_c_o = s_mid;   duty_a_o = s_last;  end
      svpwm_pkg::Sext4: begin duty_c_o = s_first; duty_b_o = s_mid;   duty_a_o = s_last;  end
      svpwm_pkg::Sext5: begin duty_c_o = s_first; duty_a_o = s_mid;   duty_b_o = s_last;  end
      default:          begin duty_a_o = s_first; duty_c_o = s_mid;   duty_b_o = s_last;  end
    endcase
  end

endmodule

/* sv/space_vector_pwm_timing_unit.sv */
// Top level of the space vector PWM timing unit: pipeline control and stage registers.
//
// Usage:
//   Input channel: alpha_volts_i / beta_volts_i (signed, FRAC_BITS fraction bits) qualified
//   by in_valid_i; the unit pushes back with in_stall_o. A transaction completes at a
//   rising edge with in_valid_i high and in_stall_o low.
//   Output channel: duty_a_o / duty_b_o / duty_c_o (signed Q4.FRAC_BITS, saturated) and
//   range_status_o (1 when any duty lies outside [0,1]) qualified by out_valid_o; the
//   receiver pushes back with out_stall_i.
//   Path: the transaction lands in the input register; projection multiply, sextant and
//   on-time select, and duty/round/saturate then fill the projection, sextant and output
//   registers in turn, and out_valid_o rises once the output register holds the result.
//   Throughput: one vector per cycle unless stalled; the single multiplier of the
//   projection stage and the adder chain of the duty stage are each used once per vector.
//   Stall: each stage advances when it is empty or the stage after it advances, so
//   bubbles collapse; a stalled result holds in the output register while earlier stages
//   keep filling, and in_stall_o rises only once all four stages hold data.
//   Reset: rst_ni clears all stage valid bits; no result is presented until new input.
//   The unit keeps no state between vectors.
module space_vector_pwm_timing_unit #(
  parameter int FRAC_BITS = svpwm_pkg::FracBitsDefault,
  parameter int IN_WIDTH  = svpwm_pkg::InWidthDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [IN_WIDTH-1:0]            alpha_volts_i,
  input  logic signed [IN_WIDTH-1:0]            beta_volts_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [svpwm_pkg::OutWidth-1:0] duty_a_o,
  output logic signed [svpwm_pkg::OutWidth-1:0] duty_b_o,
  output logic signed [svpwm_pkg::OutWidth-1:0] duty_c_o,
  output logic                                  range_status_o
);

  // Sum width covers one, the scaled projections and the doubled on-times with margin
  localparam int MaxW  = (IN_WIDTH > FRAC_BITS) ? IN_WIDTH : FRAC_BITS;
  localparam int SumW  = ((MaxW + 33) > 52) ? (MaxW + 33) : 52;
  localparam int OW    = svpwm_pkg::OutWidth;

  // Stage valid bits
  logic v0_q, v1_q, v2_q, v3_q;
  logic adv0, adv1, adv2, adv3;

  // Stage 0: input register
  logic signed [IN_WIDTH-1:0] alpha_q;
  logic signed [IN_WIDTH-1:0] beta_q;

  // Stage 1: projections
  logic signed [SumW-1:0] a_d, p_d;
  logic signed [SumW-1:0] a_q, p_q;

  // Stage 2: sextant and ordered on-times
  svpwm_pkg::sextant_e    sextant_d, sextant_q;
  logic signed [SumW-1:0] x_d, y_d;
  logic signed [SumW-1:0] x_q, y_q;

  // Stage 3: result register
  logic signed [OW-1:0] duty_a_d, duty_b_d, duty_c_d;
  logic signed [OW-1:0] duty_a_q, duty_b_q, duty_c_q;
  logic                 status_d, status_q;

  // A stage advances when empty or when its successor advances
  assign adv3 = !v3_q || !out_stall_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign adv0 = !v0_q || adv1;

  assign in_stall_o = !adv0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv0) begin
        v0_q <= in_valid_i;
      end
      if (adv1) begin
        v1_q <= v0_q;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Payload registers: load on advance, hold otherwise
  always_ff @(posedge clk_i) begin
    if (adv0) begin
      alpha_q <= alpha_volts_i;
      beta_q  <= beta_volts_i;
    end
    if (adv1) begin
      a_q <= a_d;
      p_q <= p_d;
    end
    if (adv2) begin
      sextant_q <= sextant_d;
      x_q       <= x_d;
      y_q       <= y_d;
    end
    if (adv3) begin
      duty_a_q <= duty_a_d;
      duty_b_q <= duty_b_d;
      duty_c_q <= duty_c_d;
      status_q <= status_d;
    end
  end

  svpwm_proj #(
    .IN_WIDTH (IN_WIDTH),
    .SUM_W    (SumW)
  ) u_proj (
    .alpha_i (alpha_q),
    .beta_i  (beta_q),
    .a_o     (a_d),
    .p_o     (p_d)
  );

  svpwm_sector #(
    .SUM_W (SumW)
  ) u_sector (
    .a_i       (a_q),
    .p_i       (p_q),
    .sextant_o (sextant_d),
    .x_o       (x_d),
    .y_o       (y_d)
  );

  svpwm_duty #(
    .FRAC_BITS (FRAC_BITS),
    .SUM_W     (SumW)
  ) u_duty (
    .sextant_i      (sextant_q),
    .x_i            (x_q),
    .y_i            (y_q),
    .duty_a_o       (duty_a_d),
    .duty_b_o       (duty_b_d),
    .duty_c_o       (duty_c_d),
    .range_status_o (status_d)
  );

  assign out_valid_o    = v3_q;
  assign duty_a_o       = duty_a_q;
  assign duty_b_o       = duty_b_q;
  assign duty_c_o       = duty_c_q;
  assign range_status_o = status_q;

endmodule

/* tb/svpwm_duty_checker.sv */
// Checker for the space vector PWM timing unit: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module svpwm_duty_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic                                  in_stall_i,
  input  logic signed [svpwm_pkg::InWidthDefault-1:0] alpha_volts_i,
  input  logic signed [svpwm_pkg::InWidthDefault-1:0] beta_volts_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_stall_i,
  input  logic signed [svpwm_pkg::OutWidth-1:0] duty_a_i,
  input  logic signed [svpwm_pkg::OutWidth-1:0] duty_b_i,
  input  logic signed [svpwm_pkg::OutWidth-1:0] duty_c_i,
  input  logic                                  range_status_i,
  output int                                    fail_count_o,
  output int                                    duties_pending_o
);

  localparam int     InW      = svpwm_pkg::InWidthDefault;
  localparam int     FracBits = svpwm_pkg::FracBitsDefault;
  localparam int     KShift   = svpwm_pkg::KShift;
  localparam int     OutWidth = svpwm_pkg::OutWidth;
  localparam longint InvSqrt3 = longint'(svpwm_pkg::InvSqrt3Q28);
  localparam longint DutyOne  = longint'(1) <<< (FracBits + KShift);
  localparam longint SatHi    = (longint'(1) <<< (OutWidth - 1)) - 1;
  localparam longint SatLo    = -(longint'(1) <<< (OutWidth - 1));

  typedef struct packed {
    logic signed [OutWidth-1:0] duty_a;
    logic signed [OutWidth-1:0] duty_b;
    logic signed [OutWidth-1:0] duty_c;
    logic                       range_status;
  } phase_duties_t;

  phase_duties_t expected_duties[$];

  // Round twice-the-duty at the wide scale to FRAC_BITS, half up.
  function automatic longint round_half_duty(input longint twice_duty);
    return (twice_duty + (longint'(1) <<< KShift)) >>> (KShift + 1);
  endfunction

  function automatic logic [OutWidth-1:0] clamp_duty(input longint q);
    longint c;
    c = q;
    if (c > SatHi) c = SatHi;
    if (c < SatLo) c = SatLo;
    return c[OutWidth-1:0];
  endfunction

  function automatic phase_duties_t predict_duties(input logic signed [InW-1:0] alpha,
                                                   input logic signed [InW-1:0] beta);
    longint              a, p, da, db, dc, ta, tb;
    longint              q[3];
    svpwm_pkg::sextant_e sext;
    phase_duties_t       res;
    a = longint'(alpha) <<< KShift;
    p = longint'(beta) * InvSqrt3;
    // Zero counts as the non-negative side; the projection test is strict.
    if (beta >= 0) begin
      if (a >= 0) sext = (p > a) ? svpwm_pkg::Sext2 : svpwm_pkg::Sext1;
      else        sext = (-p > a) ? svpwm_pkg::Sext3 : svpwm_pkg::Sext2;
    end else begin
      if (a >= 0) sext = (-p > a) ? svpwm_pkg::Sext5 : svpwm_pkg::Sext6;
      else        sext = (p > a) ? svpwm_pkg::Sext4 : svpwm_pkg::Sext5;
    end
    case (sext)
      svpwm_pkg::Sext1: begin
        ta = a - p;  tb = 2 * p;
        da = DutyOne - ta - tb; db = da + 2 * ta; dc = db + 2 * tb;
      end
      svpwm_pkg::Sext2: begin
        ta = a + p;  tb = -a + p;
        db = DutyOne - ta - tb; da = db + 2 * tb; dc = da + 2 * ta;
      end
      svpwm_pkg::Sext3: begin
        ta = 2 * p;  tb = -a - p;
        db = DutyOne - ta - tb; dc = db + 2 * ta; da = dc + 2 * tb;
      end
      svpwm_pkg::Sext4: begin
        ta = -a + p; tb = -2 * p;
        dc = DutyOne - ta - tb; db = dc + 2 * tb; da = db + 2 * ta;
      end
      svpwm_pkg::Sext5: begin
        ta = -a - p; tb = a - p;
        dc = DutyOne - ta - tb; da = dc + 2 * ta; db = da + 2 * tb;
      end
      default: begin
        ta = -2 * p; tb = a + p;
        da = DutyOne - ta - tb; dc = da + 2 * tb; db = dc + 2 * ta;
      end
    endcase
    q[0] = round_half_duty(da);
    q[1] = round_half_duty(db);
    q[2] = round_half_duty(dc);
    res.duty_a = clamp_duty(q[0]);
    res.duty_b = clamp_duty(q[1]);
    res.duty_c = clamp_duty(q[2]);
    // Range test runs on the rounded duties, before the clamp.
    res.range_status = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (q[i] < 0 || q[i] > (longint'(1) <<< FracBits)) res.range_status = 1'b1;
    end
    return res;
  endfunction

  initial begin
    fail_count_o     = 0;
    duties_pending_o = 0;
  end

  always @(posedge clk_i) begin
    phase_duties_t exp_d;
    if (rst_ni) begin
      // Compare the result first, then queue the new vector.
      if (out_valid_i && !out_stall_i) begin
        if (expected_duties.size() == 0) begin
          $error("unexpected result: duty_a=%0d duty_b=%0d duty_c=%0d range_status=%0b",
                 duty_a_i, duty_b_i, duty_c_i, range_status_i);
          fail_count_o++;
        end else begin
          exp_d = expected_duties.pop_front();
          if (duty_a_i !== exp_d.duty_a) begin
            $error("duty_a: expected %0d, got %0d", exp_d.duty_a, duty_a_i);
            fail_count_o++;
          end
          if (duty_b_i !== exp_d.duty_b) begin
            $error("duty_b: expected %0d, got %0d", exp_d.duty_b, duty_b_i);
            fail_count_o++;
          end
          if (duty_c_i !== exp_d.duty_c) begin
            $error("duty_c: expected %0d, got %0d", exp_d.duty_c, duty_c_i);
            fail_count_o++;
          end
          if (range_status_i !== exp_d.range_status) begin
            $error("range_status: expected %0b, got %0b", exp_d.range_status, range_status_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_duties.push_back(predict_duties(alpha_volts_i, beta_volts_i));
      end
      duties_pending_o = expected_duties.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// Top of the space vector PWM timing unit testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int InW = svpwm_pkg::InWidthDefault;
  localparam int OutW = svpwm_pkg::OutWidth;

  // Random part of the run, and where the pressure and full-rate stretches fall.
  localparam int RandomVectors = 900;
  localparam int HoldAtVector  = 200;
  localparam int HoldCycles    = 60;
  localparam int BurstFirst    = 500;
  localparam int BurstLast     = 650;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic signed [InW-1:0]  alpha_volts_i;
  logic signed [InW-1:0]  beta_volts_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic signed [OutW-1:0] duty_a_o;
  logic signed [OutW-1:0] duty_b_o;
  logic signed [OutW-1:0] duty_c_o;
  logic                   range_status_o;

  int fail_count;
  int duties_pending;
  int vectors_sent;
  bit hold_active;
  bit hold_done;

  space_vector_pwm_timing_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .alpha_volts_i (alpha_volts_i),
    .beta_volts_i  (beta_volts_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .duty_a_o      (duty_a_o),
    .duty_b_o      (duty_b_o),
    .duty_c_o      (duty_c_o),
    .range_status_o(range_status_o)
  );

  svpwm_duty_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .alpha_volts_i   (alpha_volts_i),
    .beta_volts_i    (beta_volts_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .duty_a_i        (duty_a_o),
    .duty_b_i        (duty_b_o),
    .duty_c_i        (duty_c_o),
    .range_status_i  (range_status_o),
    .fail_count_o    (fail_count),
    .duties_pending_o(duties_pending)
  );

  // 12 ns clock period.
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Mostly back-to-back or short gaps, now and then a long one. Drop all gaps while the
  // receiver holds off, and during the full-rate stretch, so the pipeline fills up.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (hold_active || (vectors_sent >= BurstFirst && vectors_sent < BurstLast)) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Offer one vector at the falling edge and hold it until the unit takes it.
  // Valid stays high across back-to-back transactions.
  task automatic send_vector(input int alpha, input int beta);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i    <= 1'b0;
      alpha_volts_i <= InW'($urandom);
      beta_volts_i  <= InW'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    alpha_volts_i <= alpha[InW-1:0];
    beta_volts_i  <= beta[InW-1:0];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    vectors_sent++;
  endtask

  // Alpha on the beta/sqrt(3) line for a given beta, so that nudges around it
  // land on either side of the sextant boundary.
  function automatic int boundary_alpha(input int beta);
    longint prod;
    prod = longint'(beta) * longint'(svpwm_pkg::InvSqrt3Q28);
    return int'(prod >>> svpwm_pkg::KShift);
  endfunction

  task automatic send_random_vector();
    int r, alpha, beta;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      // Inside or just around the inscribed hexagon: mostly valid duties.
      alpha = $urandom_range(0, 18918) - 9459;
      beta  = $urandom_range(0, 18918) - 9459;
    end else if (r < 65) begin
      // Full field range, every bit toggles.
      alpha = int'($signed(InW'($urandom)));
      beta  = int'($signed(InW'($urandom)));
    end else if (r < 80) begin
      // Straddle the strict beta/sqrt(3) comparison on either sign.
      beta  = int'($signed(InW'($urandom)));
      alpha = boundary_alpha(beta) + $urandom_range(0, 4) - 2;
      if ($urandom_range(0, 1)) alpha = -alpha;
      if (alpha > 32767) alpha = 32767;
      if (alpha < -32768) alpha = -32768;
    end else if (r < 88) begin
      // Around the axes, where the zero-counts-as-positive rule decides.
      if ($urandom_range(0, 1)) begin
        alpha = $urandom_range(0, 4) - 2;
        beta  = int'($signed(InW'($urandom)));
      end else begin
        alpha = int'($signed(InW'($urandom)));
        beta  = $urandom_range(0, 4) - 2;
      end
    end else begin
      // Near-zero vectors: all duties close to one half.
      alpha = $urandom_range(0, 128) - 64;
      beta  = $urandom_range(0, 128) - 64;
    end
    send_vector(alpha, beta);
  endtask

  // Receiver: random stall runs, one long hold-off once the run is under way, and a quiet
  // stretch with no stall at all while the sender runs at full rate.
  initial begin
    int  run_left;
    bit  stalling;
    out_stall_i = 1'b0;
    run_left    = 0;
    stalling    = 1'b0;
    hold_active = 1'b0;
    hold_done   = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && vectors_sent >= HoldAtVector) begin
        hold_active = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_active = 1'b0;
        hold_done   = 1'b1;
        out_stall_i <= 1'b0;
      end else if (vectors_sent >= BurstFirst && vectors_sent < BurstLast) begin
        out_stall_i <= 1'b0;
      end else begin
        if (run_left == 0) begin
          stalling = ($urandom_range(0, 99) < 30);
          if (!stalling) run_left = $urandom_range(1, 8);
          else if ($urandom_range(0, 99) < 85) run_left = $urandom_range(1, 3);
          else run_left = $urandom_range(8, 40);
        end
        out_stall_i <= stalling;
        run_left--;
      end
    end
  end

  // Stimulus: reset, a directed set, the random body, then drain and give the verdict.
  initial begin
    in_valid_i    = 1'b0;
    alpha_volts_i = '0;
    beta_volts_i  = '0;
    vectors_sent  = 0;
    rst_ni        = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Origin and the corners of the input field.
    send_vector(0, 0);
    send_vector(32767, 0);
    send_vector(-32768, 0);
    send_vector(0, 32767);
    send_vector(0, -32768);
    send_vector(32767, 32767);
    send_vector(-32768, -32768);
    send_vector(32767, -32768);
    send_vector(-32768, 32767);
    // Duty exactly at one and zero, then one step past it.
    send_vector(16384, 0);
    send_vector(16385, 0);
    // Zero alpha with either sign of beta.
    send_vector(0, 8192);
    send_vector(0, -8192);
    // Either side of the beta/sqrt(3) line in all four quadrants.
    send_vector(9999, 17320);
    send_vector(10000, 17320);
    send_vector(-9999, 17320);
    send_vector(-10000, 17320);
    send_vector(9999, -17320);
    send_vector(10000, -17320);
    send_vector(-10000, -17320);
    send_vector(-9999, -17320);
    // Smallest nonzero vectors in each quadrant.
    send_vector(1, -1);
    send_vector(-1, 1);
    send_vector(-1, -1);
    send_vector(1, 1);

    for (int n = 0; n < RandomVectors; n++) send_random_vector();

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain, then give the pipeline time to show any stray result.
    while (duties_pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    if (fail_count == 0 && duties_pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
